>>> src/gemm_4x4_tile_mac_assert.svh
// Assertion macros of the gemm_4x4_tile_mac RTL.
// Depends on nothing; gemm_4x4_tile_mac.sv includes it by name.
`ifndef GEMM_4X4_TILE_MAC_ASSERT_SVH
`define GEMM_4X4_TILE_MAC_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check that is ignored while reset is asserted.
`define GMAC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define GMAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMAC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define GMAC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/gmac_pkg.sv
// Shared types and constants of the 4x4 tile MAC.
// Depends on nothing; used by every module of the block.
`default_nettype none

package gmac_pkg;

    localparam int TILE         = 4;
    localparam int TILE_ENTRIES = TILE * TILE;
    localparam int IDX_W        = 2;
    localparam int CNT_W        = 2 * IDX_W;

    // Control that travels with one reduction step through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_step;

endpackage

`default_nettype wire

>>> src/gemm_4x4_tile_mac.sv
// 4x4 GEMM tile MAC: one 4x4 output tile by outer-product accumulation.
// Each input beat is one reduction step with four A and four B values in
// signed fixed point; all sixteen products go into sixteen accumulators.
// The input channel is i_valid / o_stall, the output channel o_valid / i_stall;
// a beat moves at a rising edge with valid high and stall low.
// A step enters the input register, its sixteen products are then registered
// in the product register, and from there they are added to the accumulators.
// Steps are taken one per cycle, back to back, while no final step waits.
// On a step with i_final_step set, the finished sums are copied into a drain
// bank and the accumulators are cleared, so the next tile can start at once.
// The bank then sends sixteen result beats, B row outer and A row inner, the
// last one carrying o_tile_done. The first result beat is registered from the
// loaded bank, and the rest follow one per cycle while i_stall is low.
// The drain bank is the limit on rate: a final step waits in the pipeline while
// the previous tile's sixteen sums are still being sent, and o_stall rises
// once a further step sits in the input register behind it.
// When the receiver stalls, the output register holds its beat and the drain
// counter waits; steps keep accumulating until a final step needs the bank.
// Reset (i_rst_n low, synchronous) empties the pipeline and the drain and
// sets all accumulators to zero.
`default_nettype none
`include "gemm_4x4_tile_mac_assert.svh"

module gemm_4x4_tile_mac #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [DATA_WIDTH-1:0]         i_a_row0,
    input  logic signed [DATA_WIDTH-1:0]         i_a_row1,
    input  logic signed [DATA_WIDTH-1:0]         i_a_row2,
    input  logic signed [DATA_WIDTH-1:0]         i_a_row3,
    input  logic signed [DATA_WIDTH-1:0]         i_b_row0,
    input  logic signed [DATA_WIDTH-1:0]         i_b_row1,
    input  logic signed [DATA_WIDTH-1:0]         i_b_row2,
    input  logic signed [DATA_WIDTH-1:0]         i_b_row3,
    input  logic                                 i_final_step,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [ACC_WIDTH-1:0]          o_sum_value,
    output logic [gmac_pkg::IDX_W-1:0]           o_b_index,
    output logic [gmac_pkg::IDX_W-1:0]           o_a_index,
    output logic                                 o_tile_done
);
    import gmac_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE - 1);

    logic signed [DATA_WIDTH-1:0]   w_a [TILE];
    logic signed [DATA_WIDTH-1:0]   w_b [TILE];
    t_step                          w_step;
    logic signed [2*DATA_WIDTH-1:0] w_prod [TILE_ENTRIES];
    logic                           w_take;
    logic                           w_load;
    logic [ACC_WIDTH-1:0]           w_sum [TILE_ENTRIES];
    logic                           w_busy;

    assign w_a[0] = i_a_row0;
    assign w_a[1] = i_a_row1;
    assign w_a[2] = i_a_row2;
    assign w_a[3] = i_a_row3;
    assign w_b[0] = i_b_row0;
    assign w_b[1] = i_b_row1;
    assign w_b[2] = i_b_row2;
    assign w_b[3] = i_b_row3;

    gmac_prod #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_last  (i_final_step),
        .i_take  (w_take),
        .o_step  (w_step),
        .o_prod  (w_prod)
    );

    gmac_acc #(
        .DATA_WIDTH(DATA_WIDTH),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_prod  (w_prod),
        .i_busy  (w_busy),
        .o_take  (w_take),
        .o_load  (w_load),
        .o_sum   (w_sum)
    );

    gmac_drain #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_sum       (w_sum),
        .o_busy      (w_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sum_value (o_sum_value),
        .o_b_index   (o_b_index),
        .o_a_index   (o_a_index),
        .o_tile_done (o_tile_done)
    );

    // The input side only ever waits on a busy drain bank.
    `GMAC_ASSERT_RST(a_stall_needs_busy, i_clk, i_rst_n, o_stall |-> w_busy, "stall without busy bank")
    // A bank load never lands on a bank that is still draining.
    `GMAC_ASSERT_RST(a_load_when_free, i_clk, i_rst_n, w_load |-> !w_busy, "bank overwritten while draining")
    // A loaded bank is draining in the next cycle.
    `GMAC_ASSERT_RST(a_load_starts_drain, i_clk, i_rst_n, w_load |=> w_busy, "bank load did not start drain")
    // The tile flag marks exactly the last sum of the tile.
    `GMAC_ASSERT_RST(a_done_on_last, i_clk, i_rst_n, o_valid |-> (o_tile_done == ((o_b_index == LAST_IDX) && (o_a_index == LAST_IDX))), "tile_done on wrong sum")

endmodule

`default_nettype wire

>>> src/gmac_prod.sv
// Input register and product register stage of the 4x4 tile MAC.
// Depends on gmac_pkg.
`default_nettype none

module gmac_prod #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_a [gmac_pkg::TILE],
    input  logic signed [DATA_WIDTH-1:0] i_b [gmac_pkg::TILE],
    input  logic                         i_last,
    input  logic                         i_take,
    output gmac_pkg::t_step              o_step,
    output logic signed [2*DATA_WIDTH-1:0] o_prod [gmac_pkg::TILE_ENTRIES]
);
    import gmac_pkg::*;

    logic                           r_v1;
    logic                           r_last1;
    logic signed [DATA_WIDTH-1:0]   r_a [TILE];
    logic signed [DATA_WIDTH-1:0]   r_b [TILE];
    logic                           r_v2;
    logic                           r_last2;
    logic signed [2*DATA_WIDTH-1:0] r_prod [TILE_ENTRIES];

    // The input register holds only while its step cannot move on.
    assign o_stall = r_v1 && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (!o_stall) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_last1 <= i_last;
            for (int i = 0; i < TILE; i++) begin
                r_a[i] <= i_a[i];
                r_b[i] <= i_b[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_take) begin
            r_v2 <= r_v1;
        end
    end

    // Entry order is B row outer, A row inner.
    always_ff @(posedge i_clk) begin
        if (i_take && r_v1) begin
            r_last2 <= r_last1;
            for (int j = 0; j < TILE; j++) begin
                for (int i = 0; i < TILE; i++) begin
                    r_prod[j*TILE+i] <= r_a[i] * r_b[j];
                end
            end
        end
    end

    assign o_step.valid = r_v2;
    assign o_step.last  = r_last2;
    assign o_prod       = r_prod;

endmodule

`default_nettype wire

>>> src/gmac_acc.sv
// Sixteen accumulators of the 4x4 tile MAC; hands finished sums to the drain.
// Depends on gmac_pkg.
`default_nettype none

module gmac_acc #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gmac_pkg::t_step                i_step,
    input  logic signed [2*DATA_WIDTH-1:0] i_prod [gmac_pkg::TILE_ENTRIES],
    input  logic                           i_busy,
    output logic                           o_take,
    output logic                           o_load,
    output logic [ACC_WIDTH-1:0]           o_sum [gmac_pkg::TILE_ENTRIES]
);
    import gmac_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int XW = ACC_WIDTH + PW;

    logic [ACC_WIDTH-1:0]   r_acc [TILE_ENTRIES];
    logic signed [XW-1:0]   w_ext [TILE_ENTRIES];
    logic [ACC_WIDTH-1:0]   n_sum [TILE_ENTRIES];
    logic                   w_upd;

    // A last step waits until the drain bank is free.
    assign o_take = !i_step.valid || !i_step.last || !i_busy;
    assign w_upd  = i_step.valid && o_take;
    assign o_load = w_upd && i_step.last;

    // Sums wrap modulo the accumulator width.
    always_comb begin
        for (int k = 0; k < TILE_ENTRIES; k++) begin
            w_ext[k] = XW'(i_prod[k]);
            n_sum[k] = r_acc[k] + w_ext[k][ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TILE_ENTRIES; k++) begin
                r_acc[k] <= '0;
            end
        end else if (w_upd) begin
            for (int k = 0; k < TILE_ENTRIES; k++) begin
                r_acc[k] <= i_step.last ? '0 : n_sum[k];
            end
        end
    end

    assign o_sum = n_sum;

endmodule

`default_nettype wire

>>> src/gmac_drain.sv
// Drain bank, sum counter and output register of the 4x4 tile MAC.
// Depends on gmac_pkg.
`default_nettype none

module gmac_drain #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [ACC_WIDTH-1:0]           i_sum [gmac_pkg::TILE_ENTRIES],
    output logic                           o_busy,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [ACC_WIDTH-1:0]    o_sum_value,
    output logic [gmac_pkg::IDX_W-1:0]     o_b_index,
    output logic [gmac_pkg::IDX_W-1:0]     o_a_index,
    output logic                           o_tile_done
);
    import gmac_pkg::*;

    localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(TILE_ENTRIES - 1);

    logic [ACC_WIDTH-1:0] r_bank [TILE_ENTRIES];
    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_ov;
    logic [ACC_WIDTH-1:0] r_sum;
    logic [IDX_W-1:0]     r_bidx;
    logic [IDX_W-1:0]     r_aidx;
    logic                 r_done;
    logic                 w_emit;

    assign w_emit = r_busy && (!r_ov || !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bank <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_emit) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_ENTRY) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sum  <= r_bank[r_cnt];
            r_bidx <= r_cnt[CNT_W-1:IDX_W];
            r_aidx <= r_cnt[IDX_W-1:0];
            r_done <= (r_cnt == LAST_ENTRY);
        end
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_ov;
    assign o_sum_value = r_sum;
    assign o_b_index   = r_bidx;
    assign o_a_index   = r_aidx;
    assign o_tile_done = r_done;

endmodule

`default_nettype wire
